@@ hw/rtl/brlr_pkg.sv @@
// ----------------------------------------------------------------------------
// brlr_pkg
// Shared types and constants of the styled Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package brlr_pkg;

  localparam int COORD_BITS   = 12;
  localparam int ERR_BITS     = COORD_BITS + 3;
  localparam int PERIOD_BITS  = 4;
  localparam int CNT_BITS     = $clog2(COORD_BITS + 1);
  localparam int CFG_IDX_BITS = 1;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOT_PERIOD  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_DASH_PERIOD = CFG_IDX_BITS'(1);

  localparam logic [PERIOD_BITS-1:0] DOT_PERIOD_RESET  = PERIOD_BITS'(3);
  localparam logic [PERIOD_BITS-1:0] DASH_PERIOD_RESET = PERIOD_BITS'(10);

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // line styles
  localparam logic [1:0] STYLE_SOLID  = 2'd0;
  localparam logic [1:0] STYLE_DOTTED = 2'd1;
  localparam logic [1:0] STYLE_DASHED = 2'd2;

  typedef struct packed {
    logic                         operation;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [1:0]                   line_style;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         plot;
    logic                         last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_line;
    logic rem_start;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_rem;
    logic rem_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/brlr_rem_unit.sv @@
// ----------------------------------------------------------------------------
// brlr_rem_unit
// Bit-serial remainder of a coordinate magnitude by a style period.
// ----------------------------------------------------------------------------
module brlr_rem_unit import brlr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COORD_BITS-1:0]  mag,
  input  logic [PERIOD_BITS-1:0] period,
  output logic                   done,
  output logic [PERIOD_BITS-1:0] rem
);

  logic [COORD_BITS-1:0]  shift_r;
  logic [PERIOD_BITS-1:0] rem_r;
  logic [PERIOD_BITS-1:0] rem_nxt;
  logic [CNT_BITS-1:0]    cnt_r;
  logic                   run_r;
  logic [PERIOD_BITS:0]   trial;

  // restoring step: bring in one dividend bit, subtract if it fits
  assign trial = {rem_r, shift_r[COORD_BITS-1]};

  always_comb begin
    if (trial >= {1'b0, period}) begin
      rem_nxt = PERIOD_BITS'(trial - {1'b0, period});
    end else begin
      rem_nxt = PERIOD_BITS'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_BITS'(COORD_BITS);
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= mag;
      rem_r   <= '0;
    end else if (run_r && cnt_r != '0) begin
      shift_r <= {shift_r[COORD_BITS-2:0], 1'b0};
      rem_r   <= rem_nxt;
    end
  end

  assign done = run_r && (cnt_r == '0);
  assign rem  = rem_r;

endmodule

@@ hw/rtl/brlr_datapath.sv @@
// ----------------------------------------------------------------------------
// brlr_datapath
// Line state, Bresenham step, style residue, period registers and result
// register.
// ----------------------------------------------------------------------------
module brlr_datapath import brlr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  in_item_t                in_item,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PERIOD_BITS-1:0]  cfg_wdata,
  input  logic                    out_ready,
  output logic                    out_valid,
  output out_item_t               out_item
);

  // period registers
  logic [PERIOD_BITS-1:0] dot_period_r;
  logic [PERIOD_BITS-1:0] dash_period_r;

  // line state
  logic signed [COORD_BITS-1:0] cur_x_r;
  logic signed [COORD_BITS-1:0] cur_y_r;
  logic signed [COORD_BITS-1:0] major_end_r;
  logic signed [ERR_BITS-1:0]   err_r;
  logic [COORD_BITS-1:0]        adx_r;
  logic [COORD_BITS-1:0]        ady_r;
  logic                         x_down_r;
  logic                         y_down_r;
  logic                         x_major_r;
  logic [1:0]                   style_r;
  logic                         active_r;

  // |major| mod period, tracked along the line
  logic [PERIOD_BITS-1:0] res_r;
  logic                   res_valid_r;
  logic                   res_valid_nxt;

  logic      out_valid_r;
  out_item_t out_item_r;

  // start decode
  logic signed [COORD_BITS:0]   ld_dx;
  logic signed [COORD_BITS:0]   ld_dy;
  logic [COORD_BITS-1:0]        ld_adx;
  logic [COORD_BITS-1:0]        ld_ady;
  logic                         ld_x_major;
  logic signed [ERR_BITS-1:0]   ld_err;

  // step
  logic signed [COORD_BITS-1:0] major;
  logic signed [COORD_BITS-1:0] minor;
  logic                         major_down;
  logic                         minor_down;
  logic signed [COORD_BITS-1:0] major_nxt;
  logic signed [COORD_BITS-1:0] minor_nxt;
  logic [COORD_BITS-1:0]        major_d;
  logic [COORD_BITS-1:0]        minor_d;
  logic                         err_neg;
  logic signed [ERR_BITS-1:0]   err_nxt;
  logic                         step_done;
  logic [COORD_BITS-1:0]        major_mag;
  logic                         mag_up;
  logic [PERIOD_BITS-1:0]       period;
  logic                         styled;
  logic                         plot;
  logic [PERIOD_BITS-1:0]       res_nxt;
  out_item_t                    out_nxt;

  logic                   rem_done;
  logic [PERIOD_BITS-1:0] rem;

  // ---------------- start decode ----------------
  assign ld_dx  = (COORD_BITS+1)'(in_item.x_end) - (COORD_BITS+1)'(in_item.x_start);
  assign ld_dy  = (COORD_BITS+1)'(in_item.y_end) - (COORD_BITS+1)'(in_item.y_start);
  assign ld_adx = ld_dx[COORD_BITS] ? COORD_BITS'(-ld_dx) : COORD_BITS'(ld_dx);
  assign ld_ady = ld_dy[COORD_BITS] ? COORD_BITS'(-ld_dy) : COORD_BITS'(ld_dy);
  // equal deltas go y-major
  assign ld_x_major = ld_adx > ld_ady;

  always_comb begin
    if (ld_x_major) begin
      ld_err = {2'b00, ld_ady, 1'b0} - {3'b000, ld_adx};
    end else begin
      ld_err = {2'b00, ld_adx, 1'b0} - {3'b000, ld_ady};
    end
  end

  // ---------------- bresenham step ----------------
  assign major      = x_major_r ? cur_x_r : cur_y_r;
  assign minor      = x_major_r ? cur_y_r : cur_x_r;
  assign major_down = x_major_r ? x_down_r : y_down_r;
  assign minor_down = x_major_r ? y_down_r : x_down_r;
  assign major_d    = x_major_r ? adx_r : ady_r;
  assign minor_d    = x_major_r ? ady_r : adx_r;
  assign err_neg    = err_r[ERR_BITS-1];

  assign major_nxt = major_down ? major - COORD_BITS'(1) : major + COORD_BITS'(1);

  always_comb begin
    if (err_neg) begin
      minor_nxt = minor;
      err_nxt   = err_r + ERR_BITS'({minor_d, 1'b0});
    end else begin
      minor_nxt = minor_down ? minor - COORD_BITS'(1) : minor + COORD_BITS'(1);
      err_nxt   = err_r + ERR_BITS'({minor_d, 1'b0}) - ERR_BITS'({major_d, 1'b0});
    end
  end

  assign step_done = (major_nxt == major_end_r);

  // ---------------- style ----------------
  assign period = (style_r == STYLE_DOTTED) ? dot_period_r : dash_period_r;
  assign styled = ((style_r == STYLE_DOTTED) || (style_r == STYLE_DASHED)) &&
                  (period != '0);
  assign plot   = styled ? (res_r != '0) : 1'b1;

  assign major_mag = major[COORD_BITS-1] ? COORD_BITS'(-major) : major;
  // magnitude grows when moving away from zero
  assign mag_up    = (major == '0) || (major[COORD_BITS-1] == major_down);

  always_comb begin
    if (mag_up) begin
      res_nxt = (res_r == period - PERIOD_BITS'(1)) ? '0 : res_r + PERIOD_BITS'(1);
    end else begin
      res_nxt = (res_r == '0) ? period - PERIOD_BITS'(1) : res_r - PERIOD_BITS'(1);
    end
  end

  brlr_rem_unit u_rem (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.rem_start),
    .mag    (major_mag),
    .period (period),
    .done   (rem_done),
    .rem    (rem)
  );

  // ---------------- result ----------------
  always_comb begin
    if (active_r) begin
      out_nxt.pixel_x = cur_x_r;
      out_nxt.pixel_y = cur_y_r;
      out_nxt.plot    = plot;
      out_nxt.last    = step_done;
    end else begin
      // step with no line in progress
      out_nxt.pixel_x = '0;
      out_nxt.pixel_y = '0;
      out_nxt.plot    = 1'b0;
      out_nxt.last    = 1'b1;
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (cfg_we || cmd.load_line) begin
      res_valid_nxt = 1'b0;
    end else if (rem_done) begin
      res_valid_nxt = 1'b1;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_period_r  <= DOT_PERIOD_RESET;
      dash_period_r <= DASH_PERIOD_RESET;
      active_r      <= 1'b0;
      res_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DOT_PERIOD:  dot_period_r  <= cfg_wdata;
          CFG_DASH_PERIOD: dash_period_r <= cfg_wdata;
          default: ;
        endcase
      end
      res_valid_r <= res_valid_nxt;
      if (cmd.load_line) begin
        active_r <= ld_x_major ? (in_item.x_start != in_item.x_end)
                               : (in_item.y_start != in_item.y_end);
      end else if (cmd.emit && active_r && step_done) begin
        active_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      cur_x_r     <= in_item.x_start;
      cur_y_r     <= in_item.y_start;
      major_end_r <= ld_x_major ? in_item.x_end : in_item.y_end;
      err_r       <= ld_err;
      adx_r       <= ld_adx;
      ady_r       <= ld_ady;
      x_down_r    <= !(in_item.x_end > in_item.x_start);
      y_down_r    <= !(in_item.y_end > in_item.y_start);
      x_major_r   <= ld_x_major;
      style_r     <= in_item.line_style;
    end else if (cmd.emit && active_r) begin
      cur_x_r <= x_major_r ? major_nxt : minor_nxt;
      cur_y_r <= x_major_r ? minor_nxt : major_nxt;
      err_r   <= err_nxt;
    end
    if (rem_done) begin
      res_r <= rem;
    end else if (cmd.emit && active_r) begin
      res_r <= res_nxt;
    end
    if (cmd.emit) begin
      out_item_r <= out_nxt;
    end
  end

  assign status.need_rem = active_r && styled && !res_valid_r;
  assign status.rem_done = rem_done;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hw/rtl/brlr_ctrl.sv @@
// ----------------------------------------------------------------------------
// brlr_ctrl
// Item sequencing: start loads, steps emit, remainder pass when needed.
// ----------------------------------------------------------------------------
module brlr_ctrl import brlr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_START) begin
            cmd.load_line = 1'b1;
          end else if (status.need_rem) begin
            cmd.rem_start = 1'b1;
            state_nxt     = ST_DIVIDE;
          end else if (status.out_free) begin
            cmd.emit = 1'b1;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIVIDE: begin
        if (status.rem_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/bresenham_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Styled Bresenham line rasterizer: start items load a line, step items
// return one pixel each.
// ----------------------------------------------------------------------------
// A start item gives no result. A step item is emitted in the cycle it is
// accepted while the result register is free or being drained, so steps
// stream at one pixel per clock while the output drains and no remainder pass
// runs. The dotted/dashed test keeps a running residue of the major
// coordinate's magnitude modulo the period; the first styled step after a
// start or after a period write first runs the bit-serial remainder unit, one
// coordinate bit per cycle, before it is emitted. Solid lines and steps with
// no line in progress never wait on it. Results wait in a single output
// register; a step accepted while it is still full is held until it drains.
module bresenham_line_rasterizer_top import brlr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_item,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PERIOD_BITS-1:0]  cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  brlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_item.operation),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  brlr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
